// ===== src/graph_connected_components_defines.svh =====
// assertion macros shared by the rtl
`ifndef GRAPH_CONNECTED_COMPONENTS_DEFINES_SVH
`define GRAPH_CONNECTED_COMPONENTS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GCC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcc assertion failed");

// antecedent implies consequent in the following cycle
`define GCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcc assertion failed");

`endif

// ===== src/gcc_pkg.sv =====
`timescale 1ns / 1ps
package gcc_pkg;

    localparam int MAX_V     = 1024;
    localparam int MAX_E     = 1024;
    localparam int VADDR_W   = $clog2(MAX_V);
    localparam int HE_W      = $clog2(2 * MAX_E);
    localparam int LINK_W    = HE_W + 1;
    localparam int VTX_W     = 11;
    localparam int CIDX_W    = 10;
    localparam int LST_W     = VTX_W + CIDX_W;
    localparam int HT_W      = 2 * LINK_W;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // modes
    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // register addresses
    localparam logic [2:0] ADDR_VCNT = 3'd0;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_ADD_RD, S_ADD_WR, S_ADD_LINK,
        S_RUN_CLR, S_SCAN, S_SCAN_CHK, S_HEAD, S_STEP, S_EDGE, S_VIS,
        S_POP, S_END, S_RD1, S_RD2, S_DONE
    } t_state;

endpackage

// ===== src/graph_connected_components.sv =====
`timescale 1ns / 1ps
// add edge: a rejected edge goes straight to S_DONE; a stored one runs S_ADD_RD, S_ADD_WR
// and S_ADD_LINK once per side, then the output register; run: time grows with vertices,
// listed vertices and half-edges walked, set by the single read port of each memory
// readout: S_RD1 and S_RD2, one item at a time; the output register frees the input side
// synchronous active-low reset, then a pass over all 1024 entries clears the adjacency heads
// with s_tready low; configuration writes are taken throughout
module graph_connected_components (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // vertex_a, vertex_b, zero fill
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // component_count, vertex, component_index,
                                   // component_size, first_in_component, zero fill
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast,   // last_overall
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gcc_pkg::*;

    t_state r_state, n_state;
    logic [10:0] r_vcnt, r_edges, n_edges, r_comps, n_comps, r_ltotal, n_ltotal;
    logic [10:0] r_rpos, n_rpos, r_k, n_k, r_sp, n_sp, r_start, n_start, r_u, n_u;
    logic [10:0] r_a, n_a, r_b, n_b;
    logic [LINK_W-1:0] r_cur, n_cur, r_tail, n_tail;
    logic r_side, n_side;
    logic [1:0]  r_p_status, n_p_status;
    logic [10:0] r_p_vtx, n_p_vtx, r_p_csize, n_p_csize;
    logic [9:0]  r_p_cidx, n_p_cidx;
    logic r_p_first, n_p_first, r_p_last, n_p_last;
    logic r_ovalid, n_ovalid;
    logic [1:0]  r_o_status;
    logic [10:0] r_o_cc, r_o_vtx, r_o_csize;
    logic [9:0]  r_o_cidx;
    logic r_o_first, r_o_last, load_out;

    logic [10:0] n_eff, cur_v, cur_t, in_a, in_b, u_in;
    logic [HE_W-1:0] he_idx;
    logic [LINK_W-1:0] he_link;

    // memory ports
    logic ht_we, tgt_we, nxt_we, vis_we, stk_we, lst_we, len_we;
    logic [VADDR_W-1:0] ht_wa, ht_ra, vis_wa, vis_ra, stk_wa, stk_ra;
    logic [VADDR_W-1:0] lst_wa, lst_ra, len_wa, len_ra;
    logic [HE_W-1:0] tgt_wa, nxt_wa, he_ra;
    logic [HT_W-1:0] ht_wd, ht_rd;
    logic [10:0] tgt_wd, tgt_rd, len_wd, len_rd;
    logic [LINK_W-1:0] nxt_wd, nxt_rd, stk_wd, stk_rd;
    logic vis_wd, vis_rd;
    logic [LST_W-1:0] lst_wd, lst_rd;

    gcc_ram #(.W(HT_W), .D(MAX_V)) u_ht (.i_clk(i_clk), .i_we(ht_we), .i_waddr(ht_wa),
        .i_wdata(ht_wd), .i_raddr(ht_ra), .o_rdata(ht_rd));
    gcc_ram #(.W(11), .D(2 * MAX_E)) u_tgt (.i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_wa),
        .i_wdata(tgt_wd), .i_raddr(he_ra), .o_rdata(tgt_rd));
    gcc_ram #(.W(LINK_W), .D(2 * MAX_E)) u_nxt (.i_clk(i_clk), .i_we(nxt_we),
        .i_waddr(nxt_wa), .i_wdata(nxt_wd), .i_raddr(he_ra), .o_rdata(nxt_rd));
    gcc_ram #(.W(1), .D(MAX_V)) u_vis (.i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_wa),
        .i_wdata(vis_wd), .i_raddr(vis_ra), .o_rdata(vis_rd));
    gcc_ram #(.W(LINK_W), .D(MAX_V)) u_stk (.i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa),
        .i_wdata(stk_wd), .i_raddr(stk_ra), .o_rdata(stk_rd));
    gcc_ram #(.W(LST_W), .D(MAX_V)) u_lst (.i_clk(i_clk), .i_we(lst_we), .i_waddr(lst_wa),
        .i_wdata(lst_wd), .i_raddr(lst_ra), .o_rdata(lst_rd));
    gcc_ram #(.W(11), .D(MAX_V)) u_len (.i_clk(i_clk), .i_we(len_we), .i_waddr(len_wa),
        .i_wdata(len_wd), .i_raddr(len_ra), .o_rdata(len_rd));

    // effective vertex count and edge helpers
    assign n_eff   = (r_vcnt > 11'(MAX_V)) ? 11'(MAX_V) : r_vcnt;
    assign in_a    = s_tdata[10:0];
    assign in_b    = s_tdata[21:11];
    assign cur_v   = r_side ? r_b : r_a;
    assign cur_t   = r_side ? r_a : r_b;
    assign he_idx  = {r_edges[HE_W-2:0], r_side};
    assign he_link = LINK_W'({1'b0, he_idx}) + LINK_W'(1);
    assign u_in    = tgt_rd;
    assign load_out = (r_state == S_DONE) && (!r_ovalid || m_tready);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_edges = r_edges; n_comps = r_comps; n_ltotal = r_ltotal; n_rpos = r_rpos;
        n_k = r_k; n_sp = r_sp; n_start = r_start; n_u = r_u; n_a = r_a; n_b = r_b;
        n_cur = r_cur; n_tail = r_tail; n_side = r_side;
        n_p_status = r_p_status; n_p_vtx = r_p_vtx; n_p_csize = r_p_csize;
        n_p_cidx = r_p_cidx; n_p_first = r_p_first; n_p_last = r_p_last;
        ht_we = 1'b0; ht_wa = '0; ht_wd = '0; ht_ra = '0;
        tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; he_ra = '0;
        vis_we = 1'b0; vis_wa = '0; vis_wd = 1'b0; vis_ra = '0;
        stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
        lst_we = 1'b0; lst_wa = '0; lst_wd = '0; lst_ra = '0;
        len_we = 1'b0; len_wa = '0; len_wd = '0; len_ra = '0;
        unique case (r_state)
            S_INIT: begin
                ht_we = 1'b1;
                ht_wa = r_k[VADDR_W-1:0];
                n_k = r_k + 11'd1;
                if (r_k == 11'(MAX_V - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                lst_ra = r_rpos[VADDR_W-1:0];
                if (s_tvalid) begin
                    n_p_status = ST_OK; n_p_vtx = '0; n_p_csize = '0;
                    n_p_cidx = '0; n_p_first = 1'b0; n_p_last = 1'b0;
                    n_state = S_DONE;
                    unique case (s_tuser)
                        MODE_ADD: begin
                            if (in_a == 11'd0 || in_a > n_eff || in_b == 11'd0
                                    || in_b > n_eff) begin
                                n_p_status = ST_RANGE;
                            end else if (r_edges >= 11'(MAX_E)) begin
                                n_p_status = ST_FULL;
                            end else begin
                                n_a = in_a; n_b = in_b; n_side = 1'b0;
                                n_state = S_ADD_RD;
                            end
                        end
                        MODE_RUN: begin
                            n_k = '0; n_comps = '0; n_ltotal = '0; n_rpos = '0;
                            n_state = S_RUN_CLR;
                        end
                        MODE_READ: begin
                            if (r_rpos >= r_ltotal) begin
                                n_p_status = ST_EMPTY;
                            end else begin
                                n_state = S_RD1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // append one half-edge to the list of cur_v
            S_ADD_RD: begin
                ht_ra = VADDR_W'(cur_v - 11'd1);
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                tgt_we = 1'b1; tgt_wa = he_idx; tgt_wd = cur_t;
                nxt_we = 1'b1; nxt_wa = he_idx; nxt_wd = '0;
                ht_we = 1'b1; ht_wa = VADDR_W'(cur_v - 11'd1);
                n_tail = ht_rd[LINK_W-1:0];
                if (ht_rd[LINK_W-1:0] == '0) begin
                    ht_wd = {he_link, he_link};
                end else begin
                    ht_wd = {ht_rd[HT_W-1:LINK_W], he_link};
                end
                n_state = S_ADD_LINK;
            end
            S_ADD_LINK: begin
                if (r_tail != '0) begin
                    nxt_we = 1'b1;
                    nxt_wa = HE_W'(r_tail - LINK_W'(1));
                    nxt_wd = he_link;
                end
                if (r_side) begin
                    n_edges = r_edges + 11'd1;
                    n_state = S_DONE;
                end else begin
                    n_side = 1'b1;
                    n_state = S_ADD_RD;
                end
            end
            // clear visited marks of the active vertices
            S_RUN_CLR: begin
                if (r_k < n_eff) begin
                    vis_we = 1'b1; vis_wa = r_k[VADDR_W-1:0]; vis_wd = 1'b0;
                    n_k = r_k + 11'd1;
                end else begin
                    n_k = 11'd1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                vis_ra = VADDR_W'(r_k - 11'd1);
                n_state = (r_k > n_eff) ? S_DONE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (vis_rd) begin
                    n_k = r_k + 11'd1;
                    n_state = S_SCAN;
                end else begin
                    vis_we = 1'b1; vis_wa = VADDR_W'(r_k - 11'd1); vis_wd = 1'b1;
                    lst_we = 1'b1; lst_wa = r_ltotal[VADDR_W-1:0];
                    lst_wd = {r_comps[CIDX_W-1:0], r_k};
                    n_start = r_ltotal;
                    n_ltotal = r_ltotal + 11'd1;
                    ht_ra = VADDR_W'(r_k - 11'd1);
                    n_sp = '0;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_cur = ht_rd[HT_W-1:LINK_W];
                n_sp = r_sp + 11'd1;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_cur == '0) begin
                    stk_ra = VADDR_W'(r_sp - 11'd2);
                    n_state = (r_sp == 11'd1) ? S_END : S_POP;
                end else begin
                    he_ra = HE_W'(r_cur - LINK_W'(1));
                    n_state = S_EDGE;
                end
            end
            S_POP: begin
                n_cur = stk_rd;
                n_sp = r_sp - 11'd1;
                n_state = S_STEP;
            end
            S_EDGE: begin
                n_cur = nxt_rd;
                n_u = u_in;
                vis_ra = VADDR_W'(u_in - 11'd1);
                n_state = (u_in != 11'd0 && u_in <= n_eff) ? S_VIS : S_STEP;
            end
            S_VIS: begin
                if (vis_rd) begin
                    n_state = S_STEP;
                end else begin
                    vis_we = 1'b1; vis_wa = VADDR_W'(r_u - 11'd1); vis_wd = 1'b1;
                    lst_we = 1'b1; lst_wa = r_ltotal[VADDR_W-1:0];
                    lst_wd = {r_comps[CIDX_W-1:0], r_u};
                    n_ltotal = r_ltotal + 11'd1;
                    stk_we = 1'b1; stk_wa = VADDR_W'(r_sp - 11'd1); stk_wd = r_cur;
                    ht_ra = VADDR_W'(r_u - 11'd1);
                    n_state = S_HEAD;
                end
            end
            S_END: begin
                len_we = 1'b1; len_wa = r_comps[VADDR_W-1:0];
                len_wd = r_ltotal - r_start;
                n_comps = r_comps + 11'd1;
                n_k = r_k + 11'd1;
                n_state = S_SCAN;
            end
            // readout: entry, its component length, previous entry
            S_RD1: begin
                n_p_vtx = lst_rd[VTX_W-1:0];
                n_p_cidx = lst_rd[LST_W-1:VTX_W];
                len_ra = VADDR_W'(lst_rd[LST_W-1:VTX_W]);
                lst_ra = VADDR_W'(r_rpos - 11'd1);
                n_state = S_RD2;
            end
            S_RD2: begin
                n_p_csize = len_rd;
                n_p_first = (r_rpos == 11'd0) || (lst_rd[LST_W-1:VTX_W] != r_p_cidx);
                n_p_last = (r_rpos + 11'd1 == r_ltotal);
                n_rpos = r_rpos + 11'd1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register valid
    always_comb begin
        n_ovalid = r_ovalid;
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (m_tready) begin
            n_ovalid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_vcnt <= 11'd1;
            r_edges <= '0; r_comps <= '0; r_ltotal <= '0; r_rpos <= '0;
            r_k <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_edges <= n_edges; r_comps <= n_comps; r_ltotal <= n_ltotal;
            r_rpos <= n_rpos; r_k <= n_k; r_ovalid <= n_ovalid;
            if (psel && penable && pwrite && paddr == ADDR_VCNT) begin
                r_vcnt <= pwdata[10:0];
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_sp <= n_sp; r_start <= n_start; r_u <= n_u; r_a <= n_a; r_b <= n_b;
        r_cur <= n_cur; r_tail <= n_tail; r_side <= n_side;
        r_p_status <= n_p_status; r_p_vtx <= n_p_vtx; r_p_csize <= n_p_csize;
        r_p_cidx <= n_p_cidx; r_p_first <= n_p_first; r_p_last <= n_p_last;
        if (load_out) begin
            r_o_status <= r_p_status; r_o_cc <= r_comps; r_o_vtx <= r_p_vtx;
            r_o_cidx <= r_p_cidx; r_o_csize <= r_p_csize;
            r_o_first <= r_p_first; r_o_last <= r_p_last;
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tdata  = {4'b0, r_o_first, r_o_csize, r_o_cidx, r_o_vtx, r_o_cc};
    assign m_tuser  = r_o_status;
    assign m_tlast  = r_o_last;
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_VCNT) ? {21'b0, r_vcnt} : 32'b0;

`include "graph_connected_components_defines.svh"

    `GCC_ASSERT_IMP(a_no_accept_in_init, r_state == S_INIT, !s_tready)
    `GCC_ASSERT_IMP(a_rpos_bound, 1'b1, r_rpos <= r_ltotal)
    `GCC_ASSERT_IMP(a_edges_bound, 1'b1, r_edges <= 11'(MAX_E))
    `GCC_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, r_state != S_IDLE)
endmodule

// ===== src/gcc_ram.sv =====
`timescale 1ns / 1ps
module gcc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
